/* design/ufd_pkg.sv */
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types, constants and the crc-8 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package ufd_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;
	localparam int IDLE_W      = 17;

	localparam logic [7:0]        CRC_POLY   = 8'hD5;
	localparam logic [IDLE_W-1:0] IDLE_MAX   = {IDLE_W{1'b1}};
	localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_PAYLOAD);

	localparam logic [7:0]       SYNC_RESET  = 8'hA5;
	localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd60;
	localparam logic [15:0]      TICKS_RESET = 16'd100;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LENGTH,
		PH_TYPE,
		PH_PAYLOAD,
		PH_CHECK,
		PH_READ,
		PH_LOAD
	} phase_t;

	typedef struct packed {
		logic crc_clear;
		logic crc_update;
		logic len_load;
		logic type_load;
		logic wp_clear;
		logic wp_write;
		logic idle_clear;
		logic idle_inc;
		logic k_clear;
		logic k_inc;
		logic mem_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sync_match;
		logic len_ok;
		logic len_zero;
		logic wp_last;
		logic crc_match;
		logic timeout;
		logic emit_last;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* design/ufd_ctrl.sv */
// ----------------------------------------------------------------------------
// ufd_ctrl
// Frame parse and payload emission state machine.
// ----------------------------------------------------------------------------
module ufd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          command,
	output logic          in_ready,
	input  ufd_pkg::sts_t sts,
	output ufd_pkg::cmd_t cmd
);
	import ufd_pkg::*;

	phase_t state_q;
	phase_t state_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q != PH_READ) && (state_q != PH_LOAD);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (acc && command == CMD_TICK) begin
			if (state_q != PH_HUNT) begin
				cmd.idle_inc = 1'b1;
				if (sts.timeout) begin
					cmd.idle_clear = 1'b1;
					state_d        = PH_HUNT;
				end
			end
		end else begin
			unique case (state_q)
				PH_HUNT: begin
					if (acc) begin
						cmd.idle_clear = 1'b1;
						if (sts.sync_match) begin
							cmd.crc_clear = 1'b1;
							state_d       = PH_LENGTH;
						end
					end
				end
				PH_LENGTH: begin
					if (acc) begin
						cmd.idle_clear = 1'b1;
						if (sts.len_ok) begin
							cmd.len_load   = 1'b1;
							cmd.crc_update = 1'b1;
							state_d        = PH_TYPE;
						end else begin
							state_d = PH_HUNT;
						end
					end
				end
				PH_TYPE: begin
					if (acc) begin
						cmd.idle_clear = 1'b1;
						cmd.type_load  = 1'b1;
						cmd.wp_clear   = 1'b1;
						cmd.crc_update = 1'b1;
						state_d        = sts.len_zero ? PH_CHECK : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (acc) begin
						cmd.idle_clear = 1'b1;
						cmd.wp_write   = 1'b1;
						cmd.crc_update = 1'b1;
						if (sts.wp_last) begin
							state_d = PH_CHECK;
						end
					end
				end
				PH_CHECK: begin
					if (acc) begin
						cmd.idle_clear = 1'b1;
						cmd.k_clear    = 1'b1;
						state_d        = sts.crc_match ? PH_READ : PH_HUNT;
					end
				end
				PH_READ: begin
					cmd.mem_read = 1'b1;
					state_d      = PH_LOAD;
				end
				PH_LOAD: begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.k_inc    = 1'b1;
						state_d      = sts.emit_last ? PH_HUNT : PH_READ;
					end
				end
				default: begin
					state_d = PH_HUNT;
				end
			endcase
		end
	end

	a_good_crc_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_CHECK && acc && command == CMD_BYTE && sts.crc_match)
			|=> state_q == PH_READ)
		else $error("good frame did not start emission");

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PH_READ |=> state_q == PH_LOAD)
		else $error("payload read not followed by load");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_LOAD && sts.out_free && sts.emit_last) |=> state_q == PH_HUNT)
		else $error("last result did not return to hunting");

endmodule

/* design/ufd_dp.sv */
// ----------------------------------------------------------------------------
// ufd_dp
// Config registers, crc, counters, payload memory and output register.
// ----------------------------------------------------------------------------
module ufd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ufd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic [7:0]                      rx_byte,
	input  ufd_pkg::cmd_t                   cmd,
	output ufd_pkg::sts_t                   sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [7:0]                      msg_type,
	output logic [ufd_pkg::LEN_W-1:0]       frame_len,
	output logic [7:0]                      payload_byte,
	output logic [ufd_pkg::IDX_W-1:0]       byte_index,
	output logic                            last
);
	import ufd_pkg::*;

	logic [7:0]        sync_q;
	logic [LEN_W-1:0]  limit_q;
	logic [15:0]       ticks_q;
	logic [7:0]        crc_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        type_q;
	logic [IDX_W-1:0]  wp_q;
	logic [IDX_W-1:0]  k_q;
	logic [IDLE_W-1:0] idle_q;
	logic [IDLE_W-1:0] idle_next;
	logic [7:0]        rd_q;
	logic              ovalid_q;
	logic [7:0]        mem [MAX_PAYLOAD];
	logic [LEN_W-1:0]  limit_eff;
	logic              emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q  <= SYNC_RESET;
			limit_q <= LIMIT_RESET;
			ticks_q <= TICKS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SYNC) begin
				sync_q <= cfg_data[7:0];
			end
			if (cfg_index == CFG_LIMIT) begin
				limit_q <= cfg_data[LEN_W-1:0];
			end
			if (cfg_index == CFG_TIMEOUT) begin
				ticks_q <= cfg_data;
			end
		end
	end

	assign idle_next = (idle_q == IDLE_MAX) ? idle_q : idle_q + IDLE_W'(1);
	assign limit_eff = (limit_q < MAX_LEN) ? limit_q : MAX_LEN;
	assign emit_last = (len_q == '0) || ({1'b0, k_q} + LEN_W'(1) == len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			len_q  <= '0;
			type_q <= '0;
			wp_q   <= '0;
			k_q    <= '0;
			idle_q <= '0;
		end else begin
			if (cmd.crc_clear) begin
				crc_q <= '0;
			end else if (cmd.crc_update) begin
				crc_q <= crc8_byte(crc_q, rx_byte);
			end
			if (cmd.len_load) begin
				len_q <= rx_byte[LEN_W-1:0];
			end
			if (cmd.type_load) begin
				type_q <= rx_byte;
			end
			if (cmd.wp_clear) begin
				wp_q <= '0;
			end else if (cmd.wp_write) begin
				wp_q <= wp_q + IDX_W'(1);
			end
			if (cmd.k_clear) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (cmd.idle_clear) begin
				idle_q <= '0;
			end else if (cmd.idle_inc) begin
				idle_q <= idle_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wp_write) begin
			mem[wp_q] <= rx_byte;
		end
		if (cmd.mem_read) begin
			rd_q <= mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			msg_type     <= type_q;
			frame_len    <= len_q;
			payload_byte <= (len_q == '0) ? 8'd0 : rd_q;
			byte_index   <= k_q;
			last         <= emit_last;
		end
	end

	assign out_valid = ovalid_q;

	always_comb begin
		sts            = '0;
		sts.sync_match = (rx_byte == sync_q);
		sts.len_ok     = ({1'b0, rx_byte} <= {2'b00, limit_eff});
		sts.len_zero   = (len_q == '0);
		sts.wp_last    = ({1'b0, wp_q} + LEN_W'(1) >= len_q);
		sts.crc_match  = (rx_byte == crc_q);
		sts.timeout    = (idle_next > {1'b0, ticks_q});
		sts.emit_last  = emit_last;
		sts.out_free   = !ovalid_q || out_ready;
	end

endmodule

/* design/uart_frame_deframer_crc8.sv */
// ----------------------------------------------------------------------------
// uart_frame_deframer_crc8
// Sync/length/type/payload/crc-8 frame parser fed by uart bytes and ms ticks.
// ----------------------------------------------------------------------------
// each input request (a byte or a tick) is taken as it comes while a frame is
// being parsed; the crc-8 (poly 0xd5, init 0) is updated on every length, type
// and payload byte. the crc byte of a good frame starts emission, during which
// s_tready is low: each payload result is a payload memory read followed by an
// output register load, and the load waits while the output register is full
// and the sink holds m_tready low, so input stays blocked until the last result
// is loaded. a zero-length frame gives one result with payload 0. a bad crc
// gives nothing. there is no clearing pass after reset.
module uart_frame_deframer_crc8 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // rx_byte
	input  logic                          s_tuser,   // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// msg_type[7:0], frame_len[14:8], payload_byte[22:15], byte_index[28:23], zeros
	output logic [31:0]                   m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ufd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import ufd_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [7:0]       msg_type;
	logic [LEN_W-1:0] frame_len;
	logic [7:0]       payload_byte;
	logic [IDX_W-1:0] byte_index;

	assign cfg_ready = 1'b1;

	ufd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.command  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ufd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (s_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.msg_type     (msg_type),
		.frame_len    (frame_len),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.last         (m_tlast)
	);

	assign m_tdata = {3'b000, byte_index, payload_byte, frame_len, msg_type};

endmodule
